>>> src/zero_cross_burst_fire_modulator_assert.svh
// Assertion macros used by the modulator's checker.
`ifndef ZERO_CROSS_BURST_FIRE_MODULATOR_ASSERT_SVH
`define ZERO_CROSS_BURST_FIRE_MODULATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ZCBF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ZCBF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/zcbf_pkg.sv
// Shared constants and types of the burst-fire modulator.
package zcbf_pkg;

   // Default number of power steps in one modulation period.
   localparam int LEVELS_DEFAULT = 100;

   // Reset value of the edge lockout register, in ticks.
   localparam logic [7:0] LOCKOUT_RESET = 8'd13;

   // Item kinds carried in the func field.
   localparam logic [1:0] FUNC_SET_LEVEL = 2'd0;
   localparam logic [1:0] FUNC_TICK      = 2'd1;
   localparam logic [1:0] FUNC_EDGE      = 2'd2;

   // One result item.
   typedef struct packed {
      logic heater_on;
      logic decided;
   } result_type;

endpackage

>>> src/zcbf_core.sv
// Modulator state and per-item update logic.
module zcbf_core #(
   parameter int LEVELS = zcbf_pkg::LEVELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             func,
   input  logic [6:0]             level,
   input  logic                   line_high,
   input  logic [7:0]             lockout_ms,
   output zcbf_pkg::result_type   result
);

   localparam logic [7:0] HALF_LEVELS = 8'(LEVELS / 2);
   localparam logic [9:0] LEVELS_W    = 10'(LEVELS);

   logic [7:0] error_accum_ff, error_accum_in;
   logic [6:0] power_level_ff, power_level_in;
   logic [7:0] lockout_count_ff, lockout_count_in;
   logic       edge_armed_ff, edge_armed_in;
   logic       switch_state_ff, switch_state_in;

   logic [6:0] level_sat;
   logic [7:0] count_inc;
   logic [9:0] diff;
   logic [9:0] diff_wrap;
   logic       turn_on;
   logic       decided;

   // Saturated level, incremented lockout count and modulator step.
   always_comb begin
      level_sat = (8'(level) > 8'(LEVELS)) ? 7'(LEVELS) : level;
      count_inc = (lockout_count_ff == 8'hFF) ? lockout_count_ff : lockout_count_ff + 8'd1;
      diff      = 10'(error_accum_ff) - 10'(power_level_ff);
      turn_on   = diff[9] || (diff == 10'd0);
      diff_wrap = diff + LEVELS_W;
   end

   // Next state for each item kind.
   always_comb begin
      error_accum_in   = error_accum_ff;
      power_level_in   = power_level_ff;
      lockout_count_in = lockout_count_ff;
      edge_armed_in    = edge_armed_ff;
      switch_state_in  = switch_state_ff;
      decided          = 1'b0;
      case (func)
         zcbf_pkg::FUNC_SET_LEVEL: begin
            power_level_in = level_sat;
            error_accum_in = HALF_LEVELS;
         end
         zcbf_pkg::FUNC_TICK: begin
            lockout_count_in = count_inc;
            if (count_inc >= lockout_ms) begin
               edge_armed_in = 1'b1;
            end
         end
         zcbf_pkg::FUNC_EDGE: begin
            if (edge_armed_ff && !line_high) begin
               lockout_count_in = 8'd0;
               edge_armed_in    = 1'b0;
               switch_state_in  = turn_on;
               error_accum_in   = turn_on ? diff_wrap[7:0] : diff[7:0];
               decided          = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign result.heater_on = switch_state_in;
   assign result.decided   = decided;

   // State registers update only when an item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         error_accum_ff   <= HALF_LEVELS;
         power_level_ff   <= 7'd0;
         lockout_count_ff <= 8'd0;
         edge_armed_ff    <= 1'b1;
         switch_state_ff  <= 1'b0;
      end else if (accept) begin
         error_accum_ff   <= error_accum_in;
         power_level_ff   <= power_level_in;
         lockout_count_ff <= lockout_count_in;
         edge_armed_ff    <= edge_armed_in;
         switch_state_ff  <= switch_state_in;
      end
   end

endmodule

>>> src/zero_cross_burst_fire_modulator.sv
// Top level of the zero-cross burst-fire heater modulator.
//
// Input channel req_*: one item per handshake (req_valid high, req_stall low).
// req_func selects a new power level, a millisecond tick or a mains falling
// edge; req_level and req_line_high go with it.
// Result channel rsp_*: exactly one item per input item, in order, giving the
// switch drive and whether this item made a new on/off decision.
// csr_write_enable/csr_write_data write the edge lockout length in ticks.
// Results are registered on rsp_*. Throughput is one item per cycle while
// req_stall is low; the state update is a single short pass through the core.
// When the receiver stalls, the held result stays on rsp_* and one more item
// is taken into a skid register; req_stall then rises until it drains.
// Reset is synchronous: accumulator goes to half scale, level and lockout
// count to zero, edge detection armed, switch off, lockout register to 13,
// and both output registers empty.
module zero_cross_burst_fire_modulator #(
   parameter int LEVELS = zcbf_pkg::LEVELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [6:0] req_level,
   input  logic       req_line_high,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_heater_on,
   output logic       rsp_decided,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0]           lockout_ms_ff;
   logic                 rsp_valid_ff;
   zcbf_pkg::result_type rsp_data_ff;
   logic                 skid_valid_ff;
   zcbf_pkg::result_type skid_data_ff;

   logic                 accept;
   logic                 out_free;
   zcbf_pkg::result_type result;

   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = skid_valid_ff;

   zcbf_core #(
      .LEVELS(LEVELS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_func),
      .level     (req_level),
      .line_high (req_line_high),
      .lockout_ms(lockout_ms_ff),
      .result    (result)
   );

   // Lockout length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ms_ff <= zcbf_pkg::LOCKOUT_RESET;
      end else if (csr_write_enable) begin
         lockout_ms_ff <= csr_write_data;
      end
   end

   // Output register with a one-item skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers follow the same selection.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (out_free) begin
            rsp_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_heater_on = rsp_data_ff.heater_on;
   assign rsp_decided   = rsp_data_ff.decided;

endmodule

>>> src/zcbf_checker.sv
// Port-level checker for the modulator, bound to the top level.
`include "zero_cross_burst_fire_modulator_assert.svh"

module zcbf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_func,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_heater_on,
   input logic       rsp_decided
);

   // A taken item always leaves rsp_valid high behind it.
   `ZCBF_ASSERT_NEXT(a_accept_gives_rsp, req_valid && !req_stall, rsp_valid, "item lost")

   // The skid stage only fills behind a waiting result.
   `ZCBF_ASSERT_IMP(a_stall_needs_rsp, req_stall, rsp_valid, "stall without result")

   // Only an edge item can make a decision.
   `ZCBF_ASSERT_NEXT(a_decide_only_edge,
      req_valid && !req_stall && (req_func != zcbf_pkg::FUNC_EDGE) && (!rsp_valid || !rsp_stall),
      rsp_valid && !rsp_decided, "decision without edge")

   // A stalled result holds.
   `ZCBF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_heater_on) && $stable(rsp_decided), "stalled result changed")

endmodule

bind zero_cross_burst_fire_modulator zcbf_checker u_checker (.*);

>>> test/tb_zero_cross_burst_fire_modulator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the zero-cross burst-fire heater modulator.
module tb_zero_cross_burst_fire_modulator;

   localparam int LEVELS = zcbf_pkg::LEVELS_DEFAULT;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 4;

   // One row of the directed stimulus. A row either writes the lockout register
   // or sends the same item rpt times; typed rows carry the known result.
   typedef struct packed {
      logic       cfg;
      logic [7:0] lockout;
      logic [1:0] func;
      logic [6:0] level;
      logic       line_high;
      logic [3:0] rpt;
      logic       typed;
      logic       exp_on;
      logic       exp_dec;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_func = '0;
   logic [6:0] req_level = '0;
   logic       req_line_high = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_heater_on;
   logic       rsp_decided;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;

   // Known result of the item on the input port, used for typed table rows.
   logic       row_typed = 1'b0;
   logic       row_on = 1'b0;
   logic       row_dec = 1'b0;

   // Predicted state of the modulator.
   logic [7:0] pdm_accum;
   logic [6:0] pdm_level;
   logic [7:0] lock_count;
   logic       lock_armed;
   logic       switch_on;
   logic [7:0] lock_ticks;

   zcbf_pkg::result_type switch_expect[$];
   bit         calm = 1'b0;
   int         rsp_wait = 0;
   int         idle_cycles = 0;
   int         errors = 0;
   int         items_sent = 0;
   int         decisions = 0;
   int         on_decisions = 0;
   int         settings = 0;

   // Directed part: reset lockout first, then lockout zero.
   stim_row_type stim_rows [0:18] = '{
      // Unused code with every payload bit set changes nothing.
      '{1'b0, 8'd0, FUNC_UNUSED,              7'd127, 1'b1, 4'd1,  1'b1, 1'b0, 1'b0},
      // First edge after reset is armed; level zero keeps the switch off.
      '{1'b0, 8'd0, zcbf_pkg::FUNC_EDGE,      7'd0,   1'b0, 4'd1,  1'b1, 1'b0, 1'b1},
      // Level above full scale saturates.
      '{1'b0, 8'd0, zcbf_pkg::FUNC_SET_LEVEL, 7'd127, 1'b0, 4'd1,  1'b1, 1'b0, 1'b0},
      // One tick short of the reset lockout leaves edges disarmed.
      '{1'b0, 8'd0, zcbf_pkg::FUNC_TICK,      7'd0,   1'b0, 4'd12, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd0, zcbf_pkg::FUNC_EDGE,      7'd0,   1'b0, 4'd1,  1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd0, zcbf_pkg::FUNC_TICK,      7'd0,   1'b0, 4'd1,  1'b1, 1'b0, 1'b0},
      // Armed edge with the line high is spurious.
      '{1'b0, 8'd0, zcbf_pkg::FUNC_EDGE,      7'd0,   1'b1, 4'd1,  1'b1, 1'b0, 1'b0},
      // Full power turns the switch on.
      '{1'b0, 8'd0, zcbf_pkg::FUNC_EDGE,      7'd0,   1'b0, 4'd1,  1'b1, 1'b1, 1'b1},
      // Lockout of zero: every tick re-arms.
      '{1'b1, 8'd0, zcbf_pkg::FUNC_TICK,      7'd0,   1'b0, 4'd0,  1'b0, 1'b0, 1'b0},
      // A new level leaves the drive as it was.
      '{1'b0, 8'd0, zcbf_pkg::FUNC_SET_LEVEL, 7'd0,   1'b0, 4'd1,  1'b1, 1'b1, 1'b0},
      '{1'b0, 8'd0, zcbf_pkg::FUNC_TICK,      7'd0,   1'b0, 4'd1,  1'b1, 1'b1, 1'b0},
      '{1'b0, 8'd0, zcbf_pkg::FUNC_EDGE,      7'd0,   1'b0, 4'd1,  1'b1, 1'b0, 1'b1},
      // Half level from half scale lands exactly on zero, which counts as on.
      '{1'b0, 8'd0, zcbf_pkg::FUNC_SET_LEVEL, 7'd50,  1'b0, 4'd1,  1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd0, zcbf_pkg::FUNC_TICK,      7'd0,   1'b0, 4'd1,  1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd0, zcbf_pkg::FUNC_EDGE,      7'd0,   1'b0, 4'd1,  1'b1, 1'b1, 1'b1},
      // One step over full scale saturates as well.
      '{1'b0, 8'd0, zcbf_pkg::FUNC_SET_LEVEL, 7'd101, 1'b0, 4'd1,  1'b1, 1'b1, 1'b0},
      '{1'b0, 8'd0, zcbf_pkg::FUNC_TICK,      7'd0,   1'b0, 4'd1,  1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd0, zcbf_pkg::FUNC_EDGE,      7'd0,   1'b0, 4'd1,  1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd0, FUNC_UNUSED,              7'd0,   1'b0, 4'd1,  1'b0, 1'b0, 1'b0}
   };

   zero_cross_burst_fire_modulator #(.LEVELS(LEVELS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_level(req_level),
      .req_line_high(req_line_high),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_heater_on(rsp_heater_on),
      .rsp_decided(rsp_decided),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the predicted switch by one item and return its result.
   function automatic zcbf_pkg::result_type step_switch(input logic [1:0] func,
                                                        input logic [6:0] level,
                                                        input logic line_high);
      zcbf_pkg::result_type r;
      int diff;
      r.decided = 1'b0;
      case (func)
         zcbf_pkg::FUNC_SET_LEVEL: begin
            pdm_level = (int'(level) > LEVELS) ? 7'(LEVELS) : level;
            pdm_accum = 8'(LEVELS / 2);
         end
         zcbf_pkg::FUNC_TICK: begin
            if (lock_count != 8'hFF) lock_count = lock_count + 8'd1;
            if (lock_count >= lock_ticks) lock_armed = 1'b1;
         end
         zcbf_pkg::FUNC_EDGE: begin
            if (lock_armed && !line_high) begin
               lock_count = '0;
               lock_armed = 1'b0;
               diff = int'(pdm_accum) - int'(pdm_level);
               if (diff <= 0) begin
                  pdm_accum = 8'(diff + LEVELS);
                  switch_on = 1'b1;
               end else begin
                  pdm_accum = 8'(diff);
                  switch_on = 1'b0;
               end
               r.decided = 1'b1;
            end
         end
         default: ;
      endcase
      r.heater_on = switch_on;
      return r;
   endfunction

   // Predict accepted items and check results in one place, so that a push and a
   // pop at the same edge always happen in the same order.
   always @(posedge clock) begin
      zcbf_pkg::result_type predicted;
      zcbf_pkg::result_type wanted;
      if (reset) begin
         pdm_accum = 8'(LEVELS / 2);
         pdm_level = '0;
         lock_count = '0;
         lock_armed = 1'b1;
         switch_on = 1'b0;
         lock_ticks = zcbf_pkg::LOCKOUT_RESET;
         switch_expect.delete();
      end else begin
         if (csr_write_enable) lock_ticks = csr_write_data;
         if (req_valid && !req_stall) begin
            predicted = step_switch(req_func, req_level, req_line_high);
            if (row_typed) begin
               predicted.heater_on = row_on;
               predicted.decided = row_dec;
            end
            switch_expect.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_wait = calm ? 0 : $urandom_range(0, 3);
            if (switch_expect.size() == 0) begin
               $error("result with no item pending: heater_on %0b decided %0b",
                      rsp_heater_on, rsp_decided);
               errors++;
            end else begin
               wanted = switch_expect.pop_front();
               if (rsp_heater_on !== wanted.heater_on) begin
                  $error("heater_on: expected %0b, got %0b", wanted.heater_on, rsp_heater_on);
                  errors++;
               end
               if (rsp_decided !== wanted.decided) begin
                  $error("decided: expected %0b, got %0b", wanted.decided, rsp_decided);
                  errors++;
               end
               if (wanted.decided) begin
                  decisions++;
                  if (wanted.heater_on) on_decisions++;
               end
            end
         end
      end
   end

   // Receiver stalls for a drawn number of cycles before each result.
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_stall = 1'b1;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Send one item after a drawn gap, and wait until it is taken.
   task automatic send_item(input logic [1:0] func, input logic [6:0] level,
                            input logic line_high, input logic typed, input logic on_val,
                            input logic dec_val);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_func = 2'($urandom);
         req_level = 7'($urandom);
         req_line_high = 1'($urandom);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_func = func;
      req_level = level;
      req_line_high = line_high;
      row_typed = typed;
      row_on = on_val;
      row_dec = dec_val;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (switch_expect.size() != 0) @(posedge clock);
   endtask

   // Write the lockout register while the block is idle.
   task automatic write_lockout(input logic [7:0] ticks);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = ticks;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data = 8'($urandom);
      settings++;
   endtask

   // Random item: mostly ticks and edges so that edges keep getting re-armed.
   task automatic send_random(input int tick_pct);
      int pick;
      logic [1:0] func;
      logic [6:0] level;
      pick = $urandom_range(0, 99);
      if (pick < 6) func = zcbf_pkg::FUNC_SET_LEVEL;
      else if (pick < 8) func = FUNC_UNUSED;
      else if (pick < 8 + tick_pct) func = zcbf_pkg::FUNC_TICK;
      else func = zcbf_pkg::FUNC_EDGE;
      if ($urandom_range(0, 4) == 0) level = 7'($urandom_range(0, 127));
      else level = 7'($urandom_range(0, LEVELS));
      send_item(func, level, 1'($urandom_range(0, 4) == 0), 1'b0, 1'b0, 1'b0);
   endtask

   // Main sequence: reset, directed table, then random phases per lockout.
   initial begin
      logic [7:0] phase_lockout [6];
      int phase_items [6];
      int tick_pct;
      phase_lockout = '{8'd1, 8'd255, 8'd2, 8'd5, zcbf_pkg::LOCKOUT_RESET, 8'd1};
      phase_items = '{220, 500, 220, 220, 200, 220};
      phase_lockout[2] = 8'($urandom_range(2, 30));
      phase_lockout[5] = 8'($urandom_range(1, 255));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      settings = 1;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].cfg)
            write_lockout(stim_rows[i].lockout);
         else
            repeat (stim_rows[i].rpt)
               send_item(stim_rows[i].func, stim_rows[i].level, stim_rows[i].line_high,
                         stim_rows[i].typed, stim_rows[i].exp_on, stim_rows[i].exp_dec);
      end

      for (int p = 0; p < 6; p++) begin
         write_lockout(phase_lockout[p]);
         tick_pct = (phase_lockout[p] > 8'd20) ? 86 : 50;
         for (int n = 0; n < phase_items[p]; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            // Let the result side run dry once per phase.
            if (n == phase_items[p] / 2) hold_until_drained();
            send_random(tick_pct);
         end
      end
      calm = 1'b0;

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items under %0d lockout settings, including zero and 255.",
               items_sent, settings);
      $display("Checked %0d switch decisions, %0d of them turning the heater on.",
               decisions, on_decisions);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
